### hw/rtl/ovrb_pkg.sv
// Package for the overwriting ring with byte lookup.
// Holds the item types, record type, sequencer states and shared constants.
// Depends on nothing.
`default_nettype none

package ovrb_pkg;

	localparam int DEPTH_DEF = 16;
	// Wide enough for 64 records of 65535 bytes plus one more offset.
	localparam int SUM_W = 23;
	localparam logic [SUM_W-1:0] MAX20 = SUM_W'(20'hFFFFF);

	localparam logic [1:0] MODE_APPEND = 2'd0;
	localparam logic [1:0] MODE_FIND   = 2'd1;
	localparam logic [1:0] MODE_LOCATE = 2'd2;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] record_handle;
		logic [15:0] record_length;
		logic [19:0] byte_position;
		logic [3:0]  record_index;
		logic [15:0] offset_in_record;
	} req_t;

	typedef struct packed {
		logic        evicted_valid;
		logic [31:0] evicted_handle;
		logic        hit;
		logic [31:0] found_handle;
		logic [15:0] offset_in_found;
		logic [19:0] absolute_position;
		logic [19:0] stored_bytes;
		logic [4:0]  record_count;
	} rsp_t;

	typedef struct packed {
		logic [31:0] handle;
		logic [15:0] length;
	} rec_t;

	typedef struct packed {
		logic rotate;
		logic push;
		logic load;
	} chain_ctl_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_WALK,
		S_FINISH
	} state_t;

	function automatic logic [19:0] sat20(input logic [SUM_W-1:0] v);
		logic [19:0] r;
		if (v > MAX20) begin
			r = 20'hFFFFF;
		end else begin
			r = v[19:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/ovrb_cell.sv
// One record cell of the ring chain.
// Uses rec_t from ovrb_pkg.
`default_nettype none

module ovrb_cell
	import ovrb_pkg::*;
(
	input  wire logic clk,
	input  wire logic shift,
	input  wire logic load,
	input  wire rec_t nbr,
	input  wire rec_t new_rec,
	output rec_t      rec
);

	rec_t rec_q;

	// A shift takes the neighbor's record; a load writes the new record in place.
	always_ff @(posedge clk) begin
		if (shift) begin
			rec_q <= nbr;
		end else if (load) begin
			rec_q <= new_rec;
		end
	end

	assign rec = rec_q;

endmodule

`default_nettype wire

### hw/rtl/ovrb_chain.sv
// Row of record cells ordered oldest first, with rotate, push and load.
// Uses ovrb_pkg and ovrb_cell.
`default_nettype none

module ovrb_chain
	import ovrb_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire chain_ctl_t       ctl,
	input  wire logic [IDX_W-1:0] load_idx,
	input  wire rec_t             new_rec,
	output rec_t                  head
);

	rec_t cells [DEPTH];
	rec_t tail_in;

	// Rotating feeds the head back into the tail; pushing enters the new record.
	assign tail_in = ctl.rotate ? cells[0] : new_rec;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		rec_t nbr;
		if (i == DEPTH - 1) begin : g_tail
			assign nbr = tail_in;
		end else begin : g_mid
			assign nbr = cells[i+1];
		end
		ovrb_cell u_cell (
			.clk     (clk),
			.shift   (ctl.rotate | ctl.push),
			.load    (ctl.load && (load_idx == IDX_W'(i))),
			.nbr     (nbr),
			.new_rec (new_rec),
			.rec     (cells[i])
		);
	end

	assign head = cells[0];

endmodule

`default_nettype wire

### hw/rtl/overwriting_ring_with_byte_lookup.sv
// Overwriting ring of records with byte-position lookup, top level.
// Sequence per item: an append is accepted, then passes through S_EXEC and S_FINISH;
// the unused mode goes straight to S_FINISH; a lookup runs a walk in S_WALK that
// rotates the cell chain once, one record per cycle, and then enters S_FINISH.
// A new item is accepted only in S_IDLE, after the last result has been registered.
// Reset (arst_n low, asynchronous) empties the ring; cell contents are kept.
`default_nettype none

module overwriting_ring_with_byte_lookup
	import ovrb_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

	state_t state_q, state_d;

	// Control state.
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] total_q;
	logic             rsp_valid_q;

	// Latched item and working registers of the current item.
	req_t             req_q;
	logic [IDX_W-1:0] step_q;
	logic [SUM_W-1:0] acc_q;
	logic             hit_q;
	logic [31:0]      fhandle_q;
	logic [15:0]      foff_q;
	logic [19:0]      abs_q;
	logic             evv_q;
	logic [31:0]      evh_q;
	rsp_t             rsp_q;

	chain_ctl_t       ctl;
	rec_t             head;
	rec_t             new_rec;
	logic             ring_full;
	logic             req_fire;
	logic             rsp_load;

	// Walk datapath: the head cell holds the record at index step_q.
	logic [SUM_W-1:0] head_len;
	logic [SUM_W-1:0] acc_next;
	logic [SUM_W-1:0] pos_ext;
	logic [SUM_W-1:0] off_ext;
	logic [SUM_W-1:0] locate_sum;
	logic             step_held;
	logic             step_is_idx;

	assign req_ready = (state_q == S_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_load  = (state_q == S_FINISH) && (!rsp_valid_q || rsp_ready);

	assign ring_full   = (count_q == FULL_CNT);
	assign new_rec     = '{handle: req_q.record_handle, length: req_q.record_length};
	assign head_len    = SUM_W'(head.length);
	assign acc_next    = acc_q + head_len;
	assign pos_ext     = SUM_W'(req_q.byte_position);
	assign off_ext     = SUM_W'(req_q.offset_in_record);
	assign locate_sum  = acc_q + off_ext;
	assign step_held   = (CNT_W'(step_q) < count_q);
	assign step_is_idx = (32'(step_q) == 32'(req_q.record_index));

	ovrb_chain #(
		.DEPTH (DEPTH)
	) u_chain (
		.clk      (clk),
		.ctl      (ctl),
		.load_idx (count_q[IDX_W-1:0]),
		.new_rec  (new_rec),
		.head     (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and chain control. An append either fills the next free cell or,
	// when the ring is full, shifts the oldest record out of the head.
	always_comb begin
		state_d    = state_q;
		ctl.rotate = 1'b0;
		ctl.push   = 1'b0;
		ctl.load   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					case (req.mode) inside
						MODE_APPEND:             state_d = S_EXEC;
						MODE_FIND, MODE_LOCATE:  state_d = S_WALK;
						default:                 state_d = S_FINISH;
					endcase
				end
			end
			S_EXEC: begin
				ctl.push = ring_full;
				ctl.load = !ring_full;
				state_d  = S_FINISH;
			end
			S_WALK: begin
				ctl.rotate = 1'b1;
				if (step_q == LAST_STEP) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Record count, byte total and the output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			total_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (state_q == S_EXEC) begin
				if (ring_full) begin
					total_q <= total_q - head_len + SUM_W'(req_q.record_length);
				end else begin
					total_q <= total_q + SUM_W'(req_q.record_length);
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Item datapath. The walk always rotates the full chain so that the order of
	// the cells is restored; only indexes below the count take part in a lookup.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_q     <= req;
			step_q    <= '0;
			acc_q     <= '0;
			hit_q     <= 1'b0;
			fhandle_q <= '0;
			foff_q    <= '0;
			abs_q     <= '0;
			evv_q     <= 1'b0;
			evh_q     <= '0;
		end
		if (state_q == S_EXEC && ring_full) begin
			evv_q <= 1'b1;
			evh_q <= head.handle;
		end
		if (state_q == S_WALK) begin
			step_q <= step_q + IDX_W'(1);
			acc_q  <= acc_next;
			if (req_q.mode == MODE_FIND) begin
				if (step_held && !hit_q && (pos_ext < acc_next)) begin
					hit_q     <= 1'b1;
					fhandle_q <= head.handle;
					foff_q    <= 16'(pos_ext - acc_q);
				end
			end else begin
				if (step_held && step_is_idx && (off_ext <= head_len)) begin
					hit_q <= 1'b1;
					abs_q <= sat20(locate_sum);
				end
			end
		end
		if (rsp_load) begin
			rsp_q.evicted_valid     <= evv_q;
			rsp_q.evicted_handle    <= evh_q;
			rsp_q.hit               <= hit_q;
			rsp_q.found_handle      <= fhandle_q;
			rsp_q.offset_in_found   <= foff_q;
			rsp_q.absolute_position <= abs_q;
			rsp_q.stored_bytes      <= sat20(total_q);
			rsp_q.record_count      <= (32'(count_q) > 32'd31) ? 5'd31 : 5'(count_q);
		end
	end

endmodule

`default_nettype wire
